// ----- rtl/lpp_pkg.sv -----
// Package for the scanner packet parser with point table.
// Holds shared constants, the table entry layout and the parser-to-table job types.
// No dependencies.
package lpp_pkg;

    // Default table depth, in degrees.
    localparam int NUM_POINTS_DEF = 360;

    // Stream framing bytes.
    localparam logic [7:0] SYNC_BYTE  = 8'hFA;
    localparam logic [7:0] INDEX_LOW  = 8'hA0;
    localparam logic [7:0] INDEX_HIGH = 8'hF9;

    // Byte positions inside the 20-byte packet body.
    localparam logic [4:0] BODY_READ_FIRST = 5'd2;
    localparam logic [4:0] BODY_CKS_LOW    = 5'd18;
    localparam logic [4:0] BODY_CKS_HIGH   = 5'd19;

    // Reading byte flags.
    localparam int BAD_BIT  = 7;
    localparam int WARN_BIT = 6;

    // Register reset value.
    localparam logic [7:0] STALE_LIMIT_RST = 8'd2;

    // One table entry: 48 bits.
    typedef struct packed {
        logic [13:0] distance;
        logic [15:0] qual;
        logic [15:0] rev;
        logic        valid;
        logic        warn;
    } entry_t;

    // A finished packet handed from the parser to the table engine.
    typedef struct packed {
        logic [6:0]       pidx;
        logic [15:0][7:0] bytes;
        logic             err;
        logic [15:0]      rev;
    } job_t;

    // Table engine status seen by the parser.
    typedef struct packed {
        logic busy;
        logic clearing;
    } status_t;

    // One emitted point.
    typedef struct packed {
        logic [8:0] angle;
        entry_t     entry;
        logic       err;
        logic       last;
    } result_t;

endpackage

// ----- rtl/lpp_parser.sv -----
// Byte-level packet parser: sync hunt, index check, reading capture and checksum.
// Depends on lpp_pkg; hands finished packets to lpp_table as a job_t.
module lpp_parser
    import lpp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    input  logic [15:0] revolution,
    input  status_t     status,
    output logic        job_load,
    output job_t        job
);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_INDEX,
        PH_BODY
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [4:0]       count_reg, count_next;
    logic [6:0]       pidx_reg, pidx_next;
    logic [7:0]       low_reg, low_next;
    logic [7:0]       cks_low_reg, cks_low_next;
    logic [31:0]      acc_reg, acc_next;
    logic [15:0][7:0] bytes_reg, bytes_next;

    logic        in_fire;
    logic        at_end;
    logic [17:0] fold_sum;
    logic [15:0] fold;

    // The last body byte needs a free job slot in the table engine.
    assign at_end   = (phase_reg == PH_BODY) && (count_reg == BODY_CKS_HIGH);
    assign in_ready = !status.clearing && !(at_end && status.busy);
    assign in_fire  = in_valid && in_ready;

    // Checksum fold: low 15 bits plus the upper part, masked to 15 bits.
    assign fold_sum = {3'b000, acc_reg[14:0]} + {1'b0, acc_reg[31:15]};
    assign fold     = {1'b0, fold_sum[14:0]};

    assign job_load  = in_fire && at_end;
    assign job.pidx  = pidx_reg;
    assign job.bytes = bytes_reg;
    assign job.err   = fold != {rx_byte, cks_low_reg};
    assign job.rev   = revolution;

    // Next-state logic of the parser.
    always_comb
    begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        pidx_next    = pidx_reg;
        low_next     = low_reg;
        cks_low_next = cks_low_reg;
        acc_next     = acc_reg;
        bytes_next   = bytes_reg;
        if (in_fire)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte == SYNC_BYTE)
                        phase_next = PH_INDEX;
                end
                PH_INDEX:
                begin
                    if (rx_byte >= INDEX_LOW && rx_byte <= INDEX_HIGH)
                    begin
                        pidx_next  = 7'(rx_byte - INDEX_LOW);
                        acc_next   = {16'h0000, rx_byte, SYNC_BYTE};
                        count_next = 5'd0;
                        phase_next = PH_BODY;
                    end
                    else if (rx_byte != SYNC_BYTE)
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_BODY:
                begin
                    if (count_reg < BODY_CKS_LOW)
                    begin
                        if (count_reg >= BODY_READ_FIRST)
                            bytes_next = {rx_byte, bytes_reg[15:1]};
                        if (!count_reg[0])
                            low_next = rx_byte;
                        else
                            acc_next = {acc_reg[30:0], 1'b0} + {16'h0000, rx_byte, low_reg};
                        count_next = count_reg + 5'd1;
                    end
                    else if (count_reg == BODY_CKS_LOW)
                    begin
                        cks_low_next = rx_byte;
                        count_next   = count_reg + 5'd1;
                    end
                    else
                    begin
                        count_next = 5'd0;
                        phase_next = PH_HUNT;
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HUNT;
            count_reg   <= 5'd0;
            pidx_reg    <= 7'd0;
            low_reg     <= 8'd0;
            cks_low_reg <= 8'd0;
            acc_reg     <= 32'd0;
        end
        else
        begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            pidx_reg    <= pidx_next;
            low_reg     <= low_next;
            cks_low_reg <= cks_low_next;
            acc_reg     <= acc_next;
        end
    end

    // Reading bytes shift line; written before it is read.
    always_ff @(posedge clk)
    begin
        bytes_reg <= bytes_next;
    end

endmodule

// ----- rtl/lpp_table.sv -----
// Point table engine: clearing pass, per-point read-modify-write and result register.
// Depends on lpp_pkg; takes jobs from lpp_parser.
module lpp_table
    import lpp_pkg::*;
#(
    parameter int NUM_POINTS = NUM_POINTS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] stale_limit,
    input  logic       job_load,
    input  job_t       job,
    output status_t    status,
    output logic       out_valid,
    input  logic       out_ready,
    output result_t    out_data
);

    localparam int ADDR_W = $clog2(NUM_POINTS);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_POINTS - 1);

    // Table storage, one synchronous read port and one write port.
    entry_t mem [NUM_POINTS];
    entry_t rd_data_reg;

    logic              clearing_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic              busy_reg;
    job_t              job_reg;
    logic [1:0]        point_reg;
    logic              pend_reg;
    logic [1:0]        pend_idx_reg;
    logic [8:0]        pend_pt_reg;
    logic              pend_in_reg;
    logic              out_valid_reg;
    result_t           out_reg;

    logic              issue;
    logic [8:0]        issue_pt;
    logic              issue_in;
    logic              we;
    logic [ADDR_W-1:0] wa;
    entry_t            wd;
    entry_t            upd;
    logic [7:0]        r0, r1, r2, r3;
    logic              bad;
    logic [15:0]       age;

    assign status.busy     = busy_reg;
    assign status.clearing = clearing_reg;
    assign out_valid       = out_valid_reg;
    assign out_data        = out_reg;

    // A point read is issued only when the result register will be free in the following cycle.
    assign issue    = busy_reg && !pend_reg && (!out_valid_reg || out_ready);
    assign issue_pt = {job_reg.pidx, point_reg};
    assign issue_in = issue_pt < 9'(NUM_POINTS);

    // Update of the entry that was read last cycle.
    assign r0  = job_reg.bytes[{pend_idx_reg, 2'd0}];
    assign r1  = job_reg.bytes[{pend_idx_reg, 2'd1}];
    assign r2  = job_reg.bytes[{pend_idx_reg, 2'd2}];
    assign r3  = job_reg.bytes[{pend_idx_reg, 2'd3}];
    assign bad = job_reg.err || r1[BAD_BIT];
    assign age = job_reg.rev - rd_data_reg.rev;

    always_comb
    begin
        upd = rd_data_reg;
        if (bad)
        begin
            if (age > {8'h00, stale_limit})
                upd.valid = 1'b0;
        end
        else
        begin
            upd.distance = {r1[5:0], r0};
            upd.qual     = {r3, r2};
            upd.rev      = job_reg.rev;
            upd.valid    = 1'b1;
            upd.warn     = r1[WARN_BIT];
        end
    end

    // Write port: clearing pass first, then point updates.
    always_comb
    begin
        if (clearing_reg)
        begin
            we = 1'b1;
            wa = clr_addr_reg;
            wd = '0;
        end
        else
        begin
            we = pend_reg && pend_in_reg;
            wa = pend_pt_reg[ADDR_W-1:0];
            wd = upd;
        end
    end

    // Memory array with registered read data.
    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        if (issue && issue_in)
            rd_data_reg <= mem[issue_pt[ADDR_W-1:0]];
    end

    // Control: clearing pass, job slot and point sequencing.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            busy_reg      <= 1'b0;
            point_reg     <= 2'd0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_ADDR)
                    clearing_reg <= 1'b0;
            end
            if (job_load)
            begin
                busy_reg  <= 1'b1;
                point_reg <= 2'd0;
            end
            if (issue)
                point_reg <= point_reg + 2'd1;
            pend_reg <= issue;
            if (pend_reg && pend_idx_reg == 2'd3)
                busy_reg <= 1'b0;
            if (pend_reg)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers of the job, the pending point and the result.
    always_ff @(posedge clk)
    begin
        if (job_load)
            job_reg <= job;
        if (issue)
        begin
            pend_idx_reg <= point_reg;
            pend_pt_reg  <= issue_pt;
            pend_in_reg  <= issue_in;
        end
        if (pend_reg)
        begin
            out_reg.angle <= pend_pt_reg;
            out_reg.entry <= pend_in_reg ? upd : '0;
            out_reg.err   <= job_reg.err;
            out_reg.last  <= pend_idx_reg == 2'd3;
        end
    end

endmodule

// ----- rtl/lidar_packet_parser_point_table_core.sv -----
// Top level of the scanner packet parser with a table of points.
// Depends on lpp_pkg, lpp_parser and lpp_table.
//
// Channel   Direction  Handshake             Contents
// s_axis    in         s_tvalid / s_tready   one stream byte and the revolution count
// m_axis    out        m_tvalid / m_tready   one table point, four per packet
// cfg       in         cfg_valid / cfg_ready stale_limit register write
//
// One byte request is taken per cycle, unless the table is clearing or a packet's last
// byte waits for a free job slot. A packet's four points each pass the table's single
// read port (read, then update and write back). The last byte loads the job register;
// each point then goes through the read data register and the result register.
// After reset a clearing pass writes all NUM_POINTS entries, one a cycle, before the
// first byte is taken. A stalled output holds the last byte of the following packet.
module lidar_packet_parser_point_table_core
    import lpp_pkg::*;
#(
    parameter int NUM_POINTS = NUM_POINTS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // rx_byte[7:0], revolution[23:8]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // point_angle[8:0], distance_mm[22:9],
                                   // signal_quality[38:23], point_valid[39],
                                   // warning[40], last_update_rev[56:41], zero above
    output logic        m_tuser,   // checksum_error
    output logic        m_tlast,   // last_point
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    logic [7:0] stale_limit_reg;
    status_t    status;
    logic       job_load;
    job_t       job;
    result_t    result;

    // Configuration register write.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stale_limit_reg <= STALE_LIMIT_RST;
        else if (cfg_valid)
            stale_limit_reg <= cfg_data;
    end

    lpp_parser u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .rx_byte    (s_tdata[7:0]),
        .revolution (s_tdata[23:8]),
        .status     (status),
        .job_load   (job_load),
        .job        (job)
    );

    lpp_table #(
        .NUM_POINTS (NUM_POINTS)
    ) u_table
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .stale_limit (stale_limit_reg),
        .job_load    (job_load),
        .job         (job),
        .status      (status),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_data    (result)
    );

    // Output packing.
    assign m_tdata = {7'd0,
                      result.entry.rev,
                      result.entry.warn,
                      result.entry.valid,
                      result.entry.qual,
                      result.entry.distance,
                      result.angle};
    assign m_tuser = result.err;
    assign m_tlast = result.last;

endmodule

// ----- tb/lidar_packet_parser_point_table_core_tb.sv -----
// Self-checking testbench for lidar_packet_parser_point_table_core.
// Holds a packet parser and point table predictor in a scoreboard class, plus stream drivers.
// Depends on lpp_pkg and the core RTL.
`timescale 1ns / 1ps

// Predicts the four points of each finished packet and checks what the core emits.
class point_table_scoreboard;
    typedef enum bit [1:0] {PH_HUNT, PH_INDEX, PH_BODY} parse_phase_e;

    bit [7:0]         stale_limit;
    parse_phase_e     phase;
    bit [6:0]         pkt_index;
    bit [4:0]         body_count;
    bit [7:0]         low_hold;
    bit [31:0]        cks_acc;
    bit [15:0]        rx_cks;
    bit [7:0]         reading [16];
    lpp_pkg::entry_t  point_tab [lpp_pkg::NUM_POINTS_DEF];
    lpp_pkg::result_t expected_points [$];
    int               fail_count;

    function new();
        stale_limit = lpp_pkg::STALE_LIMIT_RST;
        phase       = PH_HUNT;
        pkt_index   = '0;
        body_count  = '0;
        low_hold    = '0;
        cks_acc     = '0;
        rx_cks      = '0;
        fail_count  = 0;
        foreach (reading[i])
            reading[i] = '0;
        foreach (point_tab[i])
            point_tab[i] = '0;
    endfunction

    function void set_stale_limit(bit [7:0] value);
        stale_limit = value;
    endfunction

    // Advances the parser by one accepted byte and queues the points it completes.
    function void note_byte(bit [7:0] b, bit [15:0] rev);
        bit [31:0]        fold;
        bit               cks_err;
        int               pt;
        bit [7:0]         r0, r1, r2, r3;
        bit [15:0]        age;
        lpp_pkg::result_t point;
        case (phase)
            PH_HUNT:
            begin
                if (b == lpp_pkg::SYNC_BYTE)
                    phase = PH_INDEX;
            end
            PH_INDEX:
            begin
                if (b >= lpp_pkg::INDEX_LOW && b <= lpp_pkg::INDEX_HIGH)
                begin
                    pkt_index  = 7'(b - lpp_pkg::INDEX_LOW);
                    cks_acc    = {16'h0000, b, lpp_pkg::SYNC_BYTE};
                    body_count = '0;
                    phase      = PH_BODY;
                end
                else if (b != lpp_pkg::SYNC_BYTE)
                begin
                    phase = PH_HUNT;
                end
            end
            PH_BODY:
            begin
                if (body_count < lpp_pkg::BODY_CKS_LOW)
                begin
                    if (body_count >= lpp_pkg::BODY_READ_FIRST)
                        reading[4'(body_count - lpp_pkg::BODY_READ_FIRST)] = b;
                    if (!body_count[0])
                        low_hold = b;
                    else
                        cks_acc = (cks_acc << 1) + {16'h0000, b, low_hold};
                    body_count++;
                end
                else if (body_count == lpp_pkg::BODY_CKS_LOW)
                begin
                    rx_cks = {8'h00, b};
                    body_count++;
                end
                else
                begin
                    rx_cks[15:8] = b;
                    phase        = PH_HUNT;
                    body_count   = '0;
                    fold    = ((cks_acc & 32'h7FFF) + (cks_acc >> 15)) & 32'h7FFF;
                    cks_err = (fold != {16'h0000, rx_cks});
                    for (int i = 0; i < 4; i++)
                    begin
                        pt = int'(pkt_index) * 4 + i;
                        r0 = reading[i * 4];
                        r1 = reading[i * 4 + 1];
                        r2 = reading[i * 4 + 2];
                        r3 = reading[i * 4 + 3];
                        if (pt < lpp_pkg::NUM_POINTS_DEF)
                        begin
                            // Bad data only ages the entry out; good data replaces it.
                            if (cks_err || r1[lpp_pkg::BAD_BIT])
                            begin
                                age = rev - point_tab[pt].rev;
                                if (age > stale_limit)
                                    point_tab[pt].valid = 1'b0;
                            end
                            else
                            begin
                                point_tab[pt].distance = {r1[5:0], r0};
                                point_tab[pt].qual     = {r3, r2};
                                point_tab[pt].rev      = rev;
                                point_tab[pt].valid    = 1'b1;
                                point_tab[pt].warn     = r1[lpp_pkg::WARN_BIT];
                            end
                            point.entry = point_tab[pt];
                        end
                        else
                        begin
                            point.entry = '0;
                        end
                        point.angle = 9'(pt);
                        point.err   = cks_err;
                        point.last  = (i == 3);
                        expected_points.push_back(point);
                    end
                end
            end
            default:
            begin
                phase = PH_HUNT;
            end
        endcase
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Checks one emitted point against the oldest pending prediction.
    function void check_point(logic [63:0] data, logic err, logic last);
        lpp_pkg::result_t want;
        if (expected_points.size() == 0)
        begin
            $error("unexpected point at angle %0d with nothing pending", data[8:0]);
            fail_count++;
            return;
        end
        want = expected_points.pop_front();
        compare_field("point_angle", want.angle, data[8:0]);
        compare_field("distance_mm", want.entry.distance, data[22:9]);
        compare_field("signal_quality", want.entry.qual, data[38:23]);
        compare_field("point_valid", want.entry.valid, data[39]);
        compare_field("warning", want.entry.warn, data[40]);
        compare_field("last_update_rev", want.entry.rev, data[56:41]);
        compare_field("tdata_padding", 0, data[63:57]);
        compare_field("checksum_error", want.err, err);
        compare_field("last_point", want.last, last);
    endfunction
endclass

module lidar_packet_parser_point_table_core_tb;
    import lpp_pkg::*;

    localparam int HALF_PERIOD = 6;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_TAIL   = 24;
    localparam int PHASE_ITEMS = 60;

    typedef bit [7:0] body_t [20];

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;

    point_table_scoreboard sb;
    int        burst_left = 0;
    int        max_gap    = 6;
    int        items_sent = 0;
    bit        hold_req   = 1'b0;
    bit [15:0] rev_now    = '0;

    always #HALF_PERIOD clk = ~clk;

    lidar_packet_parser_point_table_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Folds the ten header and body words into the 15-bit checksum.
    function automatic bit [15:0] packet_checksum(bit [7:0] idx, body_t body);
        bit [31:0] acc;
        acc = {16'h0000, idx, SYNC_BYTE};
        for (int w = 0; w < 9; w++)
            acc = (acc << 1) + {16'h0000, body[2 * w + 1], body[2 * w]};
        return 16'(((acc & 32'h7FFF) + (acc >> 15)) & 32'h7FFF);
    endfunction

    // Offers one byte request, opening a new burst after a random gap when due.
    task automatic stream_byte(input bit [7:0] b, input bit [15:0] rev);
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, max_gap)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                    : $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {rev, b};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_byte(b, rev);
        items_sent++;
        burst_left--;
    endtask

    // Sends start byte, index and body; only the final byte's revolution matters.
    task automatic send_packet(input bit [7:0] idx, input body_t body, input bit [15:0] rev);
        stream_byte(SYNC_BYTE, 16'($urandom));
        stream_byte(idx, 16'($urandom));
        for (int i = 0; i < 19; i++)
            stream_byte(body[i], 16'($urandom));
        stream_byte(body[19], rev);
    endtask

    // Stops sending and lets every pending point drain out of the core.
    task automatic wait_idle();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        while (sb.expected_points.size() != 0) @(posedge clk);
        repeat (IDLE_TAIL) @(posedge clk);
    endtask

    task automatic write_stale_limit(input bit [7:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        sb.set_stale_limit(value);
    endtask

    // Output stall pattern, with one long hold-off on request.
    initial
    begin : ready_pattern
        int span;
        int mode;
        bit rdy;
        m_tready = 1'b0;
        forever
        begin
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                mode = $urandom_range(0, 4);
                span = $urandom_range(4, 40);
                for (int k = 0; k < span; k++)
                begin
                    case (mode)
                        0:       rdy = 1'b1;
                        1:       rdy = 1'($urandom_range(0, 1));
                        2:       rdy = ($urandom_range(0, 7) != 0);
                        3:       rdy = ((k % 3) != 2);
                        default: rdy = ($urandom_range(0, 3) == 0);
                    endcase
                    m_tready <= rdy;
                    @(posedge clk);
                end
            end
        end
    end

    // Result monitor.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_point(m_tdata, m_tuser, m_tlast);
    end

    // Run limit.
    initial
    begin
        #(2 * HALF_PERIOD * 200000);
        $display("simulation failed");
        $finish;
    end

    // Main stimulus.
    initial
    begin : stimulus
        body_t     body;
        bit [15:0] cks;
        bit [7:0]  idx;
        bit [7:0]  limits [4];
        int        phase_end;
        int        pick;
        int        cut;
        sb        = new();
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Framing corner cases: noise, index out of range on both sides, repeated start.
        stream_byte(8'h00, 16'h0000);
        stream_byte(8'hFF, 16'hFFFF);
        stream_byte(SYNC_BYTE, 16'h0000);
        stream_byte(INDEX_LOW - 8'd1, 16'hFFFF);
        stream_byte(SYNC_BYTE, 16'h0000);
        stream_byte(INDEX_HIGH + 8'd1, 16'h0000);
        stream_byte(SYNC_BYTE, 16'hFFFF);
        stream_byte(SYNC_BYTE, 16'h0000);

        // Top index with extreme readings: full distance and quality with warning, bad data,
        // all zero, distance one with quality 0x00FF.
        body = '{8'h00, 8'hFF,
                 8'hFF, 8'h7F, 8'hFF, 8'hFF,
                 8'h12, 8'hBF, 8'h34, 8'h56,
                 8'h00, 8'h00, 8'h00, 8'h00,
                 8'h01, 8'h00, 8'hFF, 8'h00,
                 8'h00, 8'h00};
        cks = packet_checksum(INDEX_HIGH, body);
        body[18] = cks[7:0];
        body[19] = cks[15:8];
        stream_byte(INDEX_HIGH, 16'h1234);
        for (int i = 0; i < 19; i++)
            stream_byte(body[i], 16'hFFFF);
        stream_byte(body[19], 16'hFFFF);

        // Lowest index whose received checksum has bit 15 set.
        foreach (body[i])
            body[i] = 8'($urandom);
        cks = packet_checksum(INDEX_LOW, body);
        body[18] = cks[7:0];
        body[19] = cks[15:8] | 8'h80;
        send_packet(INDEX_LOW, body, 16'h0000);
        wait_idle();

        // Random phases, each under its own stale limit.
        limits = '{8'd0, 8'd255, 8'($urandom_range(1, 254)), STALE_LIMIT_RST};
        for (int ph = 0; ph < 4; ph++)
        begin
            write_stale_limit(limits[ph]);
            if (ph == 1)
            begin
                hold_req = 1'b1;
                max_gap  = 2;
            end
            else
            begin
                max_gap = 6;
            end
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
            begin
                pick = $urandom_range(0, 19);
                if ($urandom_range(0, 9) == 0)
                    rev_now = 16'($urandom);
                else
                    rev_now = rev_now + 16'($urandom_range(0, 3));
                if ($urandom_range(0, 3) != 0)
                    idx = INDEX_LOW + 8'($urandom_range(0, 2));
                else
                    idx = 8'($urandom_range(INDEX_LOW, INDEX_HIGH));
                if (pick < 16)
                begin
                    // Well-formed packet with a mix of good and bad readings, sometimes with a corrupted checksum.
                    foreach (body[i])
                        body[i] = 8'($urandom);
                    for (int r = 0; r < 4; r++)
                        body[3 + 4 * r][BAD_BIT] = ($urandom_range(0, 2) == 0);
                    cks = packet_checksum(idx, body);
                    body[18] = cks[7:0];
                    body[19] = cks[15:8];
                    case ($urandom_range(0, 9))
                        0:       body[18] = body[18] ^ 8'($urandom_range(1, 255));
                        1:       body[19] = body[19] | 8'h80;
                        default: ;
                    endcase
                    send_packet(idx, body, rev_now);
                end
                else if (pick < 18)
                begin
                    stream_byte(8'($urandom), 16'($urandom));
                end
                else
                begin
                    // Truncated packet that the parser will run into the next one.
                    stream_byte(SYNC_BYTE, 16'($urandom));
                    stream_byte(idx, 16'($urandom));
                    cut = $urandom_range(1, 19);
                    for (int i = 0; i < cut; i++)
                        stream_byte(8'($urandom), 16'($urandom));
                end
            end
            wait_idle();
        end

        if (sb.fail_count == 0 && sb.expected_points.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

// ----- files.f -----
rtl/lpp_pkg.sv
rtl/lpp_parser.sv
rtl/lpp_table.sv
rtl/lidar_packet_parser_point_table_core.sv
tb/lidar_packet_parser_point_table_core_tb.sv
